[design/audio_noise_gate_core_defines.svh]
// Assertion macros shared by the noise gate RTL.
`ifndef AUDIO_NOISE_GATE_CORE_DEFINES_SVH
`define AUDIO_NOISE_GATE_CORE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define ANG_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define ANG_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);

`endif

[design/ang_pkg.sv]
// Types, constants and tables of the audio noise gate.
`default_nettype none
package ang_pkg;
   localparam int SAMPLE_BITS = 24;
   localparam logic [23:0] GAIN_ONE = 24'd8388608;
   localparam logic [23:0] GAIN_FLOOR = 24'd8389;
   localparam logic [31:0] DB_PER_OCTAVE_Q16 = 32'd394566;
   localparam logic [31:0] OCTAVE_PER_DB_Q16 = 32'd10885;
   localparam logic [16:0] LEVEL_FLOOR_MAG = 17'd51200;
   localparam logic [31:0] ONE_Q30 = 32'd1073741824;

   localparam logic [2:0] REG_ENABLE = 3'd0;
   localparam logic [2:0] REG_THRESHOLD = 3'd1;
   localparam logic [2:0] REG_SLOPE = 3'd2;
   localparam logic [2:0] REG_ATTACK = 3'd3;
   localparam logic [2:0] REG_RELEASE = 3'd4;

   typedef struct packed {
      logic enable;
      logic signed [15:0] threshold;
      logic [15:0] slope;
      logic [23:0] attack;
      logic [23:0] release_c;
   } cfg_type;

   typedef enum logic [11:0] {
      ST_IDLE   = 12'b0000_0000_0001,
      ST_NORM   = 12'b0000_0000_0010,
      ST_SQ     = 12'b0000_0000_0100,
      ST_L2     = 12'b0000_0000_1000,
      ST_CMP    = 12'b0000_0001_0000,
      ST_GMUL   = 12'b0000_0010_0000,
      ST_EXP    = 12'b0000_0100_0000,
      ST_SHIFT  = 12'b0000_1000_0000,
      ST_SM1    = 12'b0001_0000_0000,
      ST_SM2    = 12'b0010_0000_0000,
      ST_OUTM   = 12'b0100_0000_0000,
      ST_FINISH = 12'b1000_0000_0000
   } state_type;

   function automatic logic [31:0] exp2_frac(input logic [3:0] idx);
      logic [31:0] v;
      case (idx)
         4'd0: v = 32'd1518500250;
         4'd1: v = 32'd1276901417;
         4'd2: v = 32'd1170923762;
         4'd3: v = 32'd1121280436;
         4'd4: v = 32'd1097253708;
         4'd5: v = 32'd1085434106;
         4'd6: v = 32'd1079572136;
         4'd7: v = 32'd1076653033;
         4'd8: v = 32'd1075196443;
         4'd9: v = 32'd1074468888;
         4'd10: v = 32'd1074105294;
         4'd11: v = 32'd1073923544;
         4'd12: v = 32'd1073832680;
         4'd13: v = 32'd1073787251;
         4'd14: v = 32'd1073764537;
         default: v = 32'd1073753181;
      endcase
      return v;
   endfunction
endpackage
`default_nettype wire

[design/ang_csr.sv]
// Configuration register file of the noise gate with its APB-style port.
`default_nettype none
module ang_csr
   import ang_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [4:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready,
   output cfg_type          cfg
);
   cfg_type cfg_ff, cfg_in;
   logic    wr;

   assign csr_pready = 1'b1;
   assign wr = csr_psel & csr_penable & csr_pwrite;
   assign cfg = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr) begin
         unique case (csr_paddr[4:2])
            REG_ENABLE: cfg_in.enable = csr_pwdata[0];
            REG_THRESHOLD: cfg_in.threshold = csr_pwdata[15:0];
            REG_SLOPE: cfg_in.slope = csr_pwdata[15:0];
            REG_ATTACK: cfg_in.attack = csr_pwdata[23:0];
            REG_RELEASE: cfg_in.release_c = csr_pwdata[23:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[4:2])
         REG_ENABLE: csr_prdata = {31'd0, cfg_ff.enable};
         REG_THRESHOLD: csr_prdata = {16'd0, cfg_ff.threshold};
         REG_SLOPE: csr_prdata = {16'd0, cfg_ff.slope};
         REG_ATTACK: csr_prdata = {8'd0, cfg_ff.attack};
         REG_RELEASE: csr_prdata = {8'd0, cfg_ff.release_c};
         default: csr_prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.enable <= 1'b0;
         cfg_ff.threshold <= -16'sd12800;
         cfg_ff.slope <= 16'd58982;
         cfg_ff.attack <= 24'd16742300;
         cfg_ff.release_c <= 24'd16773721;
      end else begin
         cfg_ff <= cfg_in;
      end
   end
endmodule
`default_nettype wire

[design/audio_noise_gate_core.sv]
// Top level of the audio noise gate: sequencer and shared multiplier datapath.
`default_nettype none
`include "audio_noise_gate_core_defines.svh"
// The gate takes one signed Q1.23 sample per word and returns the gated sample and the
// smoothed Q1.23 gain. From acceptance to its result a gated sample passes through
// normalization, 16 squaring steps for the log2 fraction, the dB conversion and threshold
// compare, 16 steps of the exp2 product, the shift, two smoothing steps and the output
// scaling; every step but normalization and the shift is one pass through the single
// shared 34x32 multiplier. A sample at or above threshold skips the exp2 steps, and with
// the gate disabled the sample goes straight to the result. One sample is held at a time;
// a finished result waits in the output register while the next sample may be accepted.
module audio_noise_gate_core
   import ang_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [23:0] req_tdata,   // [23:0] sample_in
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [47:0]      rsp_tdata,   // [23:0] sample_out, [47:24] gain_out
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [4:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);
   cfg_type cfg;

   ang_csr u_csr (
      .clock(clock), .reset(reset),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready), .cfg(cfg)
   );

   state_type state_ff, state_in;
   logic [23:0] raw_ff, raw_in, mag_ff, mag_in;
   logic neg_ff, neg_in;
   logic [4:0] e_ff, e_in;
   logic [31:0] m_ff, m_in, p_ff, p_in;
   logic [15:0] frac_ff, frac_in;
   logic [3:0] cnt_ff, cnt_in;
   logic signed [17:0] lvl_ff, lvl_in;
   logic [33:0] r_ff, r_in;
   logic [23:0] g_ff, g_in, target_ff, target_in, gain_ff, gain_in, c_ff, c_in;
   logic [47:0] acc_ff, acc_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [47:0] rsp_data_ff, rsp_data_in;
   logic [23:0] res_sample_ff, res_sample_in;

   logic [33:0] mul_a;
   logic [31:0] mul_b;
   logic [65:0] prod;
   logic req_fire, slot_free;
   logic [4:0] lead;
   logic [31:0] sq;
   logic [20:0] nl2;
   logic [40:0] lvl_sum;
   logic [16:0] lvl_mag;
   logic signed [17:0] diff;
   logic [15:0] h;
   logic [8:0] n;
   logic [4:0] shamt;
   logic [49:0] sm_sum;
   logic [23:0] gfl;
   logic [48:0] ym_sum;
   logic [24:0] ym;

   assign req_fire = req_tvalid & req_tready;
   assign req_tready = (state_ff == ST_IDLE);
   assign slot_free = ~rsp_valid_ff | rsp_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = rsp_data_ff;
   assign prod = {32'd0, mul_a} * {34'd0, mul_b};

   always_comb begin
      lead = 5'd0;
      for (int i = 0; i < SAMPLE_BITS; i++) begin
         if (mag_ff[i]) lead = 5'(i);
      end
   end

   assign sq = prod[61:30];
   assign nl2 = {5'd23 - e_ff, 16'd0} - {5'd0, frac_ff};
   assign lvl_sum = prod[40:0] + 41'h0FFFFFF;
   assign lvl_mag = (lvl_sum[40:24] > LEVEL_FLOOR_MAG) ? LEVEL_FLOOR_MAG : lvl_sum[40:24];
   assign diff = {{2{cfg.threshold[15]}}, cfg.threshold} - lvl_ff;
   assign h = 16'd0 - g_ff[15:0];
   assign n = {1'b0, g_ff[23:16]} + {8'd0, (g_ff[15:0] != 16'd0)};
   assign shamt = n[4:0] + 5'd7;
   assign sm_sum = {2'b0, acc_ff} + prod[49:0] + 50'd8388608;
   assign gfl = (gain_ff < GAIN_FLOOR) ? GAIN_FLOOR : gain_ff;
   assign ym_sum = prod[48:0] + 49'd4194304;
   assign ym = ym_sum[47:23];

   always_comb begin
      mul_a = 34'd0;
      mul_b = 32'd0;
      unique case (state_ff)
         ST_SQ: begin
            mul_a = {2'd0, m_ff};
            mul_b = m_ff;
         end
         ST_L2: begin
            mul_a = {13'd0, nl2};
            mul_b = DB_PER_OCTAVE_Q16;
         end
         ST_CMP: begin
            mul_a = {16'd0, diff};
            mul_b = {16'd0, cfg.slope};
         end
         ST_GMUL: begin
            mul_a = r_ff;
            mul_b = OCTAVE_PER_DB_Q16;
         end
         ST_EXP: begin
            mul_a = {2'd0, p_ff};
            mul_b = h[4'd15 - cnt_ff] ? exp2_frac(cnt_ff) : ONE_Q30;
         end
         ST_SM1: begin
            mul_a = {10'd0, (target_ff < gain_ff) ? cfg.attack : cfg.release_c};
            mul_b = {8'd0, gain_ff};
         end
         ST_SM2: begin
            mul_a = 34'h1000000 - {10'd0, c_ff};
            mul_b = {8'd0, target_ff};
         end
         ST_OUTM: begin
            mul_a = {10'd0, mag_ff};
            mul_b = {8'd0, gfl};
         end
         default: begin
            mul_a = 34'd0;
            mul_b = 32'd0;
         end
      endcase
   end

   always_comb begin
      state_in = state_ff;
      raw_in = raw_ff;
      mag_in = mag_ff;
      neg_in = neg_ff;
      e_in = e_ff;
      m_in = m_ff;
      p_in = p_ff;
      frac_in = frac_ff;
      cnt_in = cnt_ff;
      lvl_in = lvl_ff;
      r_in = r_ff;
      g_in = g_ff;
      target_in = target_ff;
      gain_in = gain_ff;
      c_in = c_ff;
      acc_in = acc_ff;
      res_sample_in = res_sample_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      rsp_data_in = rsp_data_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               raw_in = req_tdata;
               neg_in = req_tdata[23];
               mag_in = req_tdata[23] ? 24'd0 - req_tdata : req_tdata;
               res_sample_in = req_tdata;
               state_in = cfg.enable ? ST_NORM : ST_FINISH;
            end
         end
         ST_NORM: begin
            cnt_in = 4'd0;
            frac_in = 16'd0;
            e_in = lead;
            m_in = {8'd0, mag_ff} << (5'd30 - lead);
            if (mag_ff == 24'd0) begin
               lvl_in = -18'sd51200;
               state_in = ST_CMP;
            end else begin
               state_in = ST_SQ;
            end
         end
         ST_SQ: begin
            frac_in = {frac_ff[14:0], sq[31]};
            m_in = sq[31] ? {1'b0, sq[31:1]} : sq;
            cnt_in = cnt_ff + 4'd1;
            if (cnt_ff == 4'd15) state_in = ST_L2;
         end
         ST_L2: begin
            lvl_in = (e_ff == 5'd23) ? 18'sd0 : -$signed({1'b0, lvl_mag});
            state_in = ST_CMP;
         end
         ST_CMP: begin
            r_in = prod[33:0];
            if (lvl_ff < $signed({{2{cfg.threshold[15]}}, cfg.threshold})) begin
               state_in = ST_GMUL;
            end else begin
               target_in = GAIN_ONE;
               state_in = ST_SM1;
            end
         end
         ST_GMUL: begin
            g_in = prod[47:24];
            p_in = ONE_Q30;
            cnt_in = 4'd0;
            state_in = ST_EXP;
         end
         ST_EXP: begin
            p_in = prod[61:30];
            cnt_in = cnt_ff + 4'd1;
            if (cnt_ff == 4'd15) state_in = ST_SHIFT;
         end
         ST_SHIFT: begin
            target_in = (n > 9'd24) ? 24'd0 : 24'(p_ff >> shamt);
            state_in = ST_SM1;
         end
         ST_SM1: begin
            c_in = (target_ff < gain_ff) ? cfg.attack : cfg.release_c;
            acc_in = prod[47:0];
            state_in = ST_SM2;
         end
         ST_SM2: begin
            gain_in = sm_sum[47:24];
            state_in = ST_OUTM;
         end
         ST_OUTM: begin
            res_sample_in = neg_ff ? 24'd0 - ym[23:0] : ym[23:0];
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in = {gain_ff, res_sample_ff};
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         gain_ff <= GAIN_ONE;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         gain_ff <= gain_in;
      end
   end

   always_ff @(posedge clock) begin
      raw_ff <= raw_in;
      mag_ff <= mag_in;
      neg_ff <= neg_in;
      e_ff <= e_in;
      m_ff <= m_in;
      p_ff <= p_in;
      frac_ff <= frac_in;
      cnt_ff <= cnt_in;
      lvl_ff <= lvl_in;
      r_ff <= r_in;
      g_ff <= g_in;
      target_ff <= target_in;
      c_ff <= c_in;
      acc_ff <= acc_in;
      res_sample_ff <= res_sample_in;
      rsp_data_ff <= rsp_data_in;
   end

   `ANG_ASSERT_NEXT(a_busy_after_accept, req_fire, state_ff != ST_IDLE, "idle after accept")
   `ANG_ASSERT_NOW(a_gain_bounded, 1'b1, gain_ff <= GAIN_ONE, "gain above one")
   `ANG_ASSERT_NEXT(a_finish_holds, (state_ff == ST_FINISH) && rsp_valid_ff && !rsp_tready, state_ff == ST_FINISH, "result overwritten")
   `ANG_ASSERT_NOW(a_bypass_raw, (state_ff == ST_FINISH) && !cfg.enable, res_sample_ff == raw_ff, "bypass altered sample")
endmodule
`default_nettype wire
